>>> rtl/sst_pkg.sv
package sst_pkg;

    // Default widths of the position and line fields
    localparam int POSITION_BITS_DEF = 32;
    localparam int LINE_BITS_DEF     = 24;

    // Scanner modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_INT   = 5'b00010,
        MODE_IDENT = 5'b00100,
        MODE_COLON = 5'b01000,
        MODE_DONE  = 5'b10000
    } mode_t;

    // Token kinds
    localparam logic [2:0] K_INT     = 3'd0;
    localparam logic [2:0] K_IDENT   = 3'd1;
    localparam logic [2:0] K_KEYWORD = 3'd2;
    localparam logic [2:0] K_OP      = 3'd3;
    localparam logic [2:0] K_EOF     = 3'd4;
    localparam logic [2:0] K_ERROR   = 3'd5;

    // Error codes
    localparam logic [63:0] ERR_INVALID  = 64'd0;
    localparam logic [63:0] ERR_OVERFLOW = 64'd1;
    localparam logic [63:0] ERR_UNDEF_OP = 64'd2;

    // Operator codes
    localparam logic [3:0] OP_ASSIGN = 4'd0;
    localparam logic [3:0] OP_DEFINE = 4'd1;
    localparam logic [3:0] OP_PLUS   = 4'd2;
    localparam logic [3:0] OP_MINUS  = 4'd3;
    localparam logic [3:0] OP_STAR   = 4'd4;
    localparam logic [3:0] OP_SLASH  = 4'd5;
    localparam logic [3:0] OP_LPAREN = 4'd6;
    localparam logic [3:0] OP_RPAREN = 4'd7;
    localparam logic [3:0] OP_LBRACE = 4'd8;
    localparam logic [3:0] OP_RBRACE = 4'd9;

    // Characters of interest
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Keywords packed first byte lowest: print, send, if, else, while
    localparam int          KW_COUNT = 5;
    localparam int          KW_BYTES = 5;
    localparam logic [39:0] KW_PACKED [KW_COUNT] = '{
        40'h746E697270,
        40'h00646E6573,
        40'h0000006669,
        40'h0065736C65,
        40'h656C696877
    };

    // Largest accumulator that can still take one more digit
    localparam logic [63:0] U64_TENTH = 64'd1844674407370955161;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Result queue depth, power of two
    localparam int RQ_DEPTH = 4;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } lookup_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic lookup_t single_op(input logic [7:0] c);
        lookup_t r;
        r.hit  = 1'b1;
        r.code = OP_ASSIGN;
        unique case (c)
            8'h3D:   r.code = OP_ASSIGN;
            8'h2B:   r.code = OP_PLUS;
            8'h2D:   r.code = OP_MINUS;
            8'h2A:   r.code = OP_STAR;
            8'h2F:   r.code = OP_SLASH;
            8'h28:   r.code = OP_LPAREN;
            8'h29:   r.code = OP_RPAREN;
            8'h7B:   r.code = OP_LBRACE;
            8'h7D:   r.code = OP_RBRACE;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic lookup_t kw_lookup(input logic [39:0] prefix);
        lookup_t r;
        r.hit  = 1'b0;
        r.code = 4'd0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (KW_PACKED[i] == prefix) begin
                r.hit  = 1'b1;
                r.code = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] len);
        return (len == LEN_MAX) ? len : len + 16'd1;
    endfunction

endpackage

>>> rtl/script_source_tokenizer.sv
// Streaming source tokenizer. One source byte enters per cycle on the ch channel while ch_ready
// is high and is scanned in the cycle it is accepted; its tokens (at most two: a pending integer
// or identifier closed by the byte, then the byte's own token) go into a four-entry result queue
// that drives the token channel, one token per cycle while token_ready is high. Both tokens of a
// byte that yields two are pushed together, and ch_ready drops when the queue has fewer than two
// free entries. Tokens carry kind, value, line, start offset, length and last_of_run, which marks
// the final token caused by one byte. After EOF or an error no further tokens appear until reset.
module script_source_tokenizer
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ch_valid,
    output logic                     ch_ready,
    input  logic [7:0]               ch,
    output logic                     token_valid,
    input  logic                     token_ready,
    output logic [2:0]               token_kind,
    output logic [63:0]              token_value,
    output logic [LINE_BITS-1:0]     token_line,
    output logic [POSITION_BITS-1:0] token_start,
    output logic [15:0]              token_length,
    output logic                     last_of_run
);

    typedef struct packed {
        logic [2:0]               kind;
        logic [63:0]              value;
        logic [LINE_BITS-1:0]     line;
        logic [POSITION_BITS-1:0] start;
        logic [15:0]              length;
        logic                     last;
    } result_t;

    localparam int RES_W = $bits(result_t);
    localparam int CNT_W = $clog2(RQ_DEPTH+1);

    mode_t                    mode_reg,   mode_next;
    logic [63:0]              acc_reg,    acc_next;
    logic [LINE_BITS-1:0]     line_reg,   line_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [LINE_BITS-1:0]     pline_reg,  pline_next;
    logic [15:0]              plen_reg,   plen_next;
    logic [39:0]              prefix_reg, prefix_next;

    result_t    res0, res1, own;
    logic [1:0] res_cnt;
    logic       own_emit;
    logic       scan_byte;
    logic [63:0] digit;
    lookup_t    op;
    lookup_t    kw;
    logic       accept;
    logic       pop;
    logic [1:0] push_cnt;
    logic [CNT_W-1:0] rq_count;
    result_t    head;

    assign accept   = ch_valid && ch_ready;
    assign ch_ready = rq_count <= CNT_W'(RQ_DEPTH - 2);
    assign digit    = {60'd0, ch[3:0]};
    assign op       = single_op(ch);
    assign kw       = kw_lookup(prefix_reg);

    // Scan one byte: close the pending token, then scan the byte itself
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        pos_next    = pos_reg + POSITION_BITS'(1);
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        plen_next   = plen_reg;
        prefix_next = prefix_reg;
        res0        = '0;
        res1        = '0;
        own         = '0;
        res_cnt     = 2'd0;
        own_emit    = 1'b0;
        scan_byte   = 1'b0;

        unique case (mode_reg)
            MODE_INT:
            begin
                if (is_digit(ch))
                begin
                    if ((acc_reg > U64_TENTH) || ((acc_reg == U64_TENTH) && (ch[3:0] > 4'd5)))
                    begin
                        res0.kind   = K_ERROR;
                        res0.value  = ERR_OVERFLOW;
                        res0.line   = pline_reg;
                        res0.start  = pstart_reg;
                        res0.length = sat_inc(plen_reg);
                        res_cnt     = 2'd1;
                        mode_next   = MODE_DONE;
                    end
                    else
                    begin
                        acc_next  = (acc_reg << 3) + (acc_reg << 1) + digit;
                        plen_next = sat_inc(plen_reg);
                    end
                end
                else
                begin
                    res0.kind   = K_INT;
                    res0.value  = acc_reg;
                    res0.line   = pline_reg;
                    res0.start  = pstart_reg;
                    res0.length = plen_reg;
                    res_cnt     = 2'd1;
                    scan_byte   = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_word(ch))
                begin
                    if (plen_reg < 16'(KW_BYTES))
                    begin
                        prefix_next[8*plen_reg[2:0] +: 8] = ch;
                    end
                    plen_next = sat_inc(plen_reg);
                end
                else
                begin
                    if (kw.hit && (plen_reg <= 16'(KW_BYTES)))
                    begin
                        res0.kind  = K_KEYWORD;
                        res0.value = 64'(kw.code);
                    end
                    else
                    begin
                        res0.kind  = K_IDENT;
                        res0.value = 64'd0;
                    end
                    res0.line   = pline_reg;
                    res0.start  = pstart_reg;
                    res0.length = plen_reg;
                    res_cnt     = 2'd1;
                    scan_byte   = 1'b1;
                end
            end
            MODE_COLON:
            begin
                res0.line  = pline_reg;
                res0.start = pstart_reg;
                res_cnt    = 2'd1;
                if (ch == CH_EQUAL)
                begin
                    res0.kind   = K_OP;
                    res0.value  = 64'(OP_DEFINE);
                    res0.length = 16'd2;
                    mode_next   = MODE_IDLE;
                end
                else
                begin
                    res0.kind   = K_ERROR;
                    res0.value  = ERR_UNDEF_OP;
                    res0.length = 16'd1;
                    mode_next   = MODE_DONE;
                end
            end
            MODE_IDLE:
            begin
                scan_byte = 1'b1;
            end
            MODE_DONE:
            begin
                pos_next = pos_reg;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        // Scan the byte as the start of a new token
        if (scan_byte)
        begin
            mode_next  = MODE_IDLE;
            own.line   = line_reg;
            own.start  = pos_reg;
            own.length = 16'd1;
            if (ch == CH_NUL)
            begin
                own.kind   = K_EOF;
                own.value  = 64'd0;
                own.length = 16'd0;
                own_emit   = 1'b1;
                mode_next  = MODE_DONE;
            end
            else if (is_space(ch))
            begin
                if ((ch == CH_NEWLINE) && (line_reg != '1))
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
            else if (is_digit(ch))
            begin
                pstart_next = pos_reg;
                pline_next  = line_reg;
                plen_next   = 16'd1;
                acc_next    = digit;
                mode_next   = MODE_INT;
            end
            else if (is_alpha(ch) || (ch == CH_UNDERSCORE))
            begin
                pstart_next = pos_reg;
                pline_next  = line_reg;
                plen_next   = 16'd1;
                prefix_next = {32'd0, ch};
                mode_next   = MODE_IDENT;
            end
            else if (op.hit)
            begin
                own.kind  = K_OP;
                own.value = 64'(op.code);
                own_emit  = 1'b1;
            end
            else if (ch == CH_COLON)
            begin
                pstart_next = pos_reg;
                pline_next  = line_reg;
                plen_next   = 16'd1;
                mode_next   = MODE_COLON;
            end
            else
            begin
                own.kind  = K_ERROR;
                own.value = ERR_INVALID;
                own_emit  = 1'b1;
                mode_next = MODE_DONE;
            end
        end

        // Place the byte's own token behind any closed one, mark the last
        if (own_emit)
        begin
            if (res_cnt == 2'd0)
            begin
                res0 = own;
            end
            else
            begin
                res1 = own;
            end
            res_cnt = res_cnt + 2'd1;
        end
        if (res_cnt == 2'd2)
        begin
            res1.last = 1'b1;
        end
        else
        begin
            res0.last = 1'b1;
        end
    end

    // Hold scanner state, advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            pos_reg    <= '0;
            pstart_reg <= '0;
            pline_reg  <= LINE_BITS'(1);
            plen_reg   <= '0;
            prefix_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            plen_reg   <= plen_next;
            prefix_reg <= prefix_next;
        end
    end

    assign push_cnt = accept ? res_cnt : 2'd0;
    assign pop      = token_valid && token_ready;

    sst_rq #(
        .WIDTH (RES_W)
    ) u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (pop),
        .head_data  (head),
        .count      (rq_count)
    );

    // Drive the token channel from the queue head
    assign token_valid  = rq_count != '0;
    assign token_kind   = head.kind;
    assign token_value  = head.value;
    assign token_line   = head.line;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

`ifndef SYNTH
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |=> (mode_reg == MODE_DONE))
        else $error("scanner left the stopped mode");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_DONE)) |-> (push_cnt == 2'd0))
        else $error("token produced after stop");

    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == MODE_INT) || (mode_reg == MODE_IDENT) || (mode_reg == MODE_COLON))
        |-> (plen_reg != 16'd0))
        else $error("pending token with zero length");

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (rq_count <= CNT_W'(RQ_DEPTH - 2)))
        else $error("byte accepted without room for two tokens");
`endif

endmodule

>>> rtl/sst_rq.sv
module sst_rq
    import sst_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  logic [WIDTH-1:0] push_data0,
    input  logic [WIDTH-1:0] push_data1,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic [$clog2(RQ_DEPTH+1)-1:0] count
);

    localparam int IDX_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH+1);

    logic [WIDTH-1:0] slot_reg [RQ_DEPTH];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] tail_plus;

    // Locate the write slots behind the stored requests
    assign tail      = head_reg + count_reg[IDX_W-1:0];
    assign tail_plus = tail + IDX_W'(1);

    // Advance head and occupancy
    always_comb
    begin
        head_next  = head_reg + (pop ? IDX_W'(1) : IDX_W'(0));
        count_next = count_reg + CNT_W'(push_cnt) - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[tail] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[tail_plus] <= push_data1;
        end
    end

    assign head_data = slot_reg[head_reg];
    assign count     = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue popped while empty");

    a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (count_reg <= CNT_W'(RQ_DEPTH - 2)))
        else $error("two results pushed without room");
`endif

endmodule

>>> tb/testbench.sv
module testbench
    import sst_pkg::*;
();

    localparam int POS_W        = POSITION_BITS_DEF;
    localparam int LINE_W       = LINE_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 560;
    localparam int LONG_IDENT   = 40;
    localparam int TAIL_BYTES   = 8;
    localparam int PARK_AFTER   = 120;
    localparam int PARK_CYCLES  = 300;

    typedef struct packed {
        logic [2:0]        kind;
        logic [63:0]       value;
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  start;
        logic [15:0]       length;
        logic              last;
    } token_t;

    typedef struct packed {
        logic [7:0] value;
        logic       burst;
    } src_byte_t;

    typedef enum int {STOP_EOF, STOP_INVALID, STOP_COLON, STOP_OVERFLOW} stream_stop_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              ch_valid = 1'b0;
    logic              ch_ready;
    logic [7:0]        ch = 8'h00;
    logic              token_valid;
    logic              token_ready = 1'b0;
    logic [2:0]        token_kind;
    logic [63:0]       token_value;
    logic [LINE_W-1:0] token_line;
    logic [POS_W-1:0]  token_start;
    logic [15:0]       token_length;
    logic              last_of_run;

    // Scanner state mirrored by the predictor
    mode_t             scan_state = MODE_IDLE;
    logic [63:0]       number_acc = '0;
    logic [LINE_W-1:0] line_no    = 1;
    logic [POS_W-1:0]  src_pos    = '0;
    logic [POS_W-1:0]  pend_start = '0;
    logic [LINE_W-1:0] pend_line  = 1;
    logic [15:0]       pend_len   = '0;
    logic [39:0]       kw_prefix  = '0;

    token_t    expected_tokens [$];
    src_byte_t pending_bytes [$];

    string kw_text [KW_COUNT] = '{"print", "send", "if", "else", "while"};
    string op_text = "=+-*/(){}";

    int  cycle_count     = 0;
    int  error_count     = 0;
    int  tokens_checked  = 0;
    int  bytes_accepted  = 0;
    int  bytes_total     = 0;
    int  send_gap        = 0;
    int  ready_hold      = 0;
    int  ready_eager     = 0;
    bit  ch_taken        = 1'b0;
    bit  receiver_parked = 1'b0;

    script_source_tokenizer #(
        .POSITION_BITS (POS_W),
        .LINE_BITS     (LINE_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch_valid     (ch_valid),
        .ch_ready     (ch_ready),
        .ch           (ch),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .token_line   (token_line),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit char_is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit char_is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic bit char_is_space(input logic [7:0] c);
        return (c == " ") || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic lookup_t op_lookup(input logic [7:0] c);
        lookup_t r;
        r.hit  = 1'b1;
        r.code = OP_ASSIGN;
        case (c)
            "=":     r.code = OP_ASSIGN;
            "+":     r.code = OP_PLUS;
            "-":     r.code = OP_MINUS;
            "*":     r.code = OP_STAR;
            "/":     r.code = OP_SLASH;
            "(":     r.code = OP_LPAREN;
            ")":     r.code = OP_RPAREN;
            "{":     r.code = OP_LBRACE;
            "}":     r.code = OP_RBRACE;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic bit is_token_byte(input logic [7:0] c);
        return char_is_space(c) || char_is_digit(c) || char_is_alpha(c)
            || c == CH_UNDERSCORE || c == CH_COLON || op_lookup(c).hit;
    endfunction

    function automatic logic [15:0] len_step(input logic [15:0] len);
        return (len == LEN_MAX) ? len : len + 16'd1;
    endfunction

    function automatic token_t make_token(input logic [2:0] kind, input logic [63:0] value,
                                          input logic [LINE_W-1:0] line,
                                          input logic [POS_W-1:0] start,
                                          input logic [15:0] length);
        token_t t;
        t.kind   = kind;
        t.value  = value;
        t.line   = line;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

    // Scan one accepted byte and queue the tokens it yields
    task automatic scan_byte(input logic [7:0] c);
        token_t      found [2];
        int          n;
        bit          consumed;
        lookup_t     op;
        logic [63:0] d;
        logic [2:0]  kind;
        logic [63:0] value;
        n        = 0;
        consumed = 1'b0;
        if (scan_state != MODE_DONE)
        begin
            // close or extend the pending token
            case (scan_state)
                MODE_INT:
                begin
                    if (char_is_digit(c))
                    begin
                        d = 64'(c - "0");
                        if (number_acc > U64_TENTH || (number_acc == U64_TENTH && d > 64'd5))
                        begin
                            found[n] = make_token(K_ERROR, ERR_OVERFLOW, pend_line, pend_start,
                                                  len_step(pend_len));
                            n++;
                            scan_state = MODE_DONE;
                        end
                        else
                        begin
                            number_acc = number_acc * 64'd10 + d;
                            pend_len   = len_step(pend_len);
                        end
                        consumed = 1'b1;
                    end
                    else
                    begin
                        found[n] = make_token(K_INT, number_acc, pend_line, pend_start, pend_len);
                        n++;
                        scan_state = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (char_is_digit(c) || char_is_alpha(c) || c == CH_UNDERSCORE)
                    begin
                        if (pend_len < 16'd5)
                            kw_prefix = kw_prefix | (40'(c) << (pend_len * 8));
                        pend_len = len_step(pend_len);
                        consumed = 1'b1;
                    end
                    else
                    begin
                        kind  = K_IDENT;
                        value = '0;
                        if (pend_len <= 16'd5)
                        begin
                            for (int i = 0; i < KW_COUNT; i++)
                            begin
                                if (KW_PACKED[i] == kw_prefix)
                                begin
                                    kind  = K_KEYWORD;
                                    value = 64'(i);
                                end
                            end
                        end
                        found[n] = make_token(kind, value, pend_line, pend_start, pend_len);
                        n++;
                        scan_state = MODE_IDLE;
                    end
                end
                MODE_COLON:
                begin
                    if (c == CH_EQUAL)
                    begin
                        found[n] = make_token(K_OP, 64'(OP_DEFINE), pend_line, pend_start, 16'd2);
                        scan_state = MODE_IDLE;
                    end
                    else
                    begin
                        found[n] = make_token(K_ERROR, ERR_UNDEF_OP, pend_line, pend_start,
                                              16'd1);
                        scan_state = MODE_DONE;
                    end
                    n++;
                    consumed = 1'b1;
                end
                default:
                begin
                end
            endcase

            // scan the byte as the start of a new token
            if (!consumed)
            begin
                op = op_lookup(c);
                if (c == CH_NUL)
                begin
                    found[n] = make_token(K_EOF, 64'd0, line_no, src_pos, 16'd0);
                    n++;
                    scan_state = MODE_DONE;
                end
                else if (char_is_space(c))
                begin
                    if (c == CH_NEWLINE && line_no != {LINE_W{1'b1}})
                        line_no = line_no + 1'b1;
                end
                else if (char_is_digit(c) || char_is_alpha(c) || c == CH_UNDERSCORE
                         || c == CH_COLON)
                begin
                    pend_start = src_pos;
                    pend_line  = line_no;
                    pend_len   = 16'd1;
                    if (char_is_digit(c))
                    begin
                        number_acc = 64'(c - "0");
                        scan_state = MODE_INT;
                    end
                    else if (c == CH_COLON)
                        scan_state = MODE_COLON;
                    else
                    begin
                        kw_prefix  = 40'(c);
                        scan_state = MODE_IDENT;
                    end
                end
                else if (op.hit)
                begin
                    found[n] = make_token(K_OP, 64'(op.code), line_no, src_pos, 16'd1);
                    n++;
                end
                else
                begin
                    found[n] = make_token(K_ERROR, ERR_INVALID, line_no, src_pos, 16'd1);
                    n++;
                    scan_state = MODE_DONE;
                end
            end

            src_pos = src_pos + 1'b1;
            if (n > 0)
                found[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_tokens.push_back(found[i]);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Most gaps short, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] random_space();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3)
            return CH_NEWLINE;
        else if (r < 5)
            return " ";
        else
            return 8'(8'h09 + $urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] ident_char(input bit first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return CH_UNDERSCORE;
        else
            return 8'("0" + r - 53);
    endfunction

    task automatic queue_byte(input logic [7:0] c, input bit burst);
        src_byte_t b;
        b.value = c;
        b.burst = burst;
        pending_bytes.push_back(b);
    endtask

    task automatic queue_text(input string s, input bit burst);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], burst);
    endtask

    task automatic queue_number(input logic [63:0] v, input int zeros, input bit burst);
        logic [7:0]  digits [$];
        logic [63:0] rest;
        rest = v;
        repeat (zeros) queue_byte("0", burst);
        do
        begin
            digits.push_front(8'("0" + rest % 10));
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (digits[i])
            queue_byte(digits[i], burst);
    endtask

    // Accept requests, predict, check tokens, watch the cycle budget
    always @(posedge clk)
    begin
        token_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            ch_taken = rst_n && ch_valid && ch_ready;
            if (ch_taken)
            begin
                scan_byte(ch);
                bytes_accepted++;
            end
            if (rst_n && token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d value %0h start %0d",
                           token_kind, token_value, token_start);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_field("token_kind", 64'(want.kind), 64'(token_kind));
                    compare_field("token_value", want.value, token_value);
                    compare_field("token_line", 64'(want.line), 64'(token_line));
                    compare_field("token_start", 64'(want.start), 64'(token_start));
                    compare_field("token_length", 64'(want.length), 64'(token_length));
                    compare_field("last_of_run", 64'(want.last), 64'(last_of_run));
                    tokens_checked++;
                end
            end
        end
    end

    // Offer source bytes, hold each until taken
    always @(negedge clk)
    begin
        src_byte_t item;
        if (!rst_n)
            ch_valid <= 1'b0;
        else if (!ch_valid || ch_taken)
        begin
            if (send_gap > 0)
            begin
                ch_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() != 0)
            begin
                item = pending_bytes.pop_front();
                ch       <= item.value;
                ch_valid <= 1'b1;
                if (!item.burst)
                    send_gap = random_gap();
            end
            else
                ch_valid <= 1'b0;
        end
    end

    // Stall the token side at random, with eager stretches
    always @(negedge clk)
    begin
        if (!rst_n || receiver_parked)
            token_ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            token_ready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            token_ready <= 1'b1;
            if (ready_eager > 0)
                ready_eager--;
            else if ($urandom_range(0, 49) == 0)
                ready_eager = $urandom_range(20, 80);
            else if ($urandom_range(0, 2) == 0)
                ready_hold = random_gap();
        end
    end

    // Park the receiver once so the result queue fills and ch_ready drops
    initial
    begin
        while (tokens_checked < PARK_AFTER)
            @(negedge clk);
        @(posedge clk);
        receiver_parked = 1'b1;
        repeat (PARK_CYCLES) @(posedge clk);
        receiver_parked = 1'b0;
    end

    initial
    begin
        bit           last_int;
        bit           last_word;
        bit           burst_run;
        int           first_random;
        int           r;
        int           len;
        logic [63:0]  num;
        logic [7:0]   c;
        stream_stop_t stop_kind;

        last_int  = 1'b0;
        last_word = 1'b0;
        burst_run = 1'b0;

        // Directed: keywords, near-keywords, whitespace, operators, integer extremes
        queue_byte(CH_NEWLINE, 1'b0);
        queue_text("print send if else while ", 1'b0);
        queue_text("prints whil Else _ _9aZ zA_0 abcde", 1'b0);
        for (int k = 9; k <= 13; k++)
            queue_byte(8'(k), 1'b0);
        queue_text("= := + - * / ( ) { } 0 007 ", 1'b0);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
        queue_text(" 12+ab(3)x:=4", 1'b0);
        queue_byte(CH_NEWLINE, 1'b0);
        queue_text("if{y}7:=while", 1'b0);
        queue_byte(CH_NEWLINE, 1'b0);

        // Long identifier that starts with a keyword
        queue_text("while", 1'b1);
        repeat (LONG_IDENT - 5) queue_byte("q", 1'b1);
        queue_byte(" ", 1'b1);

        // Random well-formed token stream
        first_random = pending_bytes.size();
        while (pending_bytes.size() - first_random < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 19) == 0)
                burst_run = !burst_run;
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                queue_byte(random_space(), burst_run);
                last_int  = 1'b0;
                last_word = 1'b0;
            end
            else if (r < 67)
            begin
                // separate most words; never let two integers merge
                if ((last_int || last_word) && $urandom_range(0, 3) != 0)
                    queue_byte(" ", burst_run);
                else if (last_int && r >= 47)
                    queue_byte(" ", burst_run);
                if (r < 47)
                begin
                    if ($urandom_range(0, 3) == 0)
                        queue_text(kw_text[$urandom_range(0, KW_COUNT - 1)], burst_run);
                    else
                    begin
                        len = $urandom_range(1, 9);
                        queue_byte(ident_char(1'b1), burst_run);
                        for (int i = 1; i < len; i++)
                            queue_byte(ident_char(1'b0), burst_run);
                    end
                    last_int  = 1'b0;
                    last_word = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: num = 64'($urandom_range(0, 999));
                        5, 6, 7:       num = {$urandom, $urandom};
                        default:       num = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20);
                    endcase
                    queue_number(num, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                                 burst_run);
                    last_int  = 1'b1;
                    last_word = 1'b0;
                end
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r == 9)
                    queue_text(":=", burst_run);
                else
                    queue_byte(op_text[r], burst_run);
                last_int  = 1'b0;
                last_word = 1'b0;
            end
        end

        // Stop the stream one way, then feed bytes that must be ignored
        stop_kind = stream_stop_t'($urandom_range(0, 3));
        case (stop_kind)
            STOP_EOF:
                queue_byte(CH_NUL, 1'b0);
            STOP_INVALID:
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (is_token_byte(c));
                queue_byte(c, 1'b0);
            end
            STOP_COLON:
            begin
                queue_byte(CH_COLON, 1'b0);
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_EQUAL);
                queue_byte(c, 1'b0);
            end
            default:
            begin
                if (last_int || last_word)
                    queue_byte(" ", 1'b0);
                case ($urandom_range(0, 2))
                    0: queue_text("18446744073709551616", 1'b0);
                    1:
                    begin
                        queue_text("1844674407370955161", 1'b0);
                        queue_byte(8'("6" + $urandom_range(0, 3)), 1'b0);
                    end
                    default: queue_text("99999999999999999999", 1'b0);
                endcase
            end
        endcase
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        repeat (TAIL_BYTES - 2) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        bytes_total = pending_bytes.size();

        // Reset once
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every byte taken, every token seen, then let the bench idle
        while (bytes_accepted < bytes_total || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Fed %0d source bytes: directed tokens, a %0d-byte identifier, random streams",
                 bytes_total, LONG_IDENT);
        $display("Checked %0d tokens; stream stopped by %s, then %0d bytes ignored",
                 tokens_checked, stop_kind.name(), TAIL_BYTES);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/sst_pkg.sv
rtl/sst_rq.sv
rtl/script_source_tokenizer.sv
tb/testbench.sv
